/* rtl/bpr_pkg.sv */
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types and codes for the button press/release tracker.
// ----------------------------------------------------------------------------
package bpr_pkg;

	localparam int LEVEL_W = 8;
	localparam int TIME_W  = 32;
	localparam int CHAN_W  = 8;

	typedef enum logic [0:0] {
		OP_TICK  = 1'b0,
		OP_QUERY = 1'b1
	} bpr_op_t;

	typedef struct packed {
		bpr_op_t             operation;
		logic [LEVEL_W-1:0]  button_levels;
		logic [TIME_W-1:0]   now_ms;
		logic [CHAN_W-1:0]   channel;
	} bpr_req_t;

	typedef struct packed {
		logic                is_pressed;
		logic                is_released;
		logic                press_seen;
		logic                release_seen;
		logic [TIME_W-1:0]   press_duration;
		logic [TIME_W-1:0]   release_duration;
		logic                bad_channel;
	} bpr_rsp_t;

	// strobes from the top level into the channel bank
	typedef struct packed {
		logic tick;
		logic query;
	} bpr_cmd_t;

endpackage

/* rtl/bpr_if.sv */
// ----------------------------------------------------------------------------
// bpr_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface bpr_req_if;
	logic               valid;
	logic               ready;
	bpr_pkg::bpr_req_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface bpr_rsp_if;
	logic               valid;
	logic               ready;
	bpr_pkg::bpr_rsp_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/button_press_release_tracker.sv */
// ----------------------------------------------------------------------------
// button_press_release_tracker
// Tracks press/release flags, events and durations of several buttons.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink): one beat per item. A tick beat carries the raw button levels
//     (bit per channel) and the current millisecond time; it updates every
//     channel and returns nothing. A query beat names a channel; it returns
//     one rsp beat with flags, sticky events and durations, then clears that
//     channel's two events.
//   rsp (source): one beat per query, in request order. An out-of-range
//     channel gives an all-zero beat with bad_channel set, state untouched.
//   Path: a query accepted into the input stage moves on into the result
//     register, which drives rsp. Throughput: one beat per cycle unless rsp
//     stalls, set by the single input stage feeding one result register.
//   Stall: while a result waits on rsp, ticks still drain and a following
//     query is held in the input stage; req.ready drops only when that stage
//     holds a query that cannot move.
//   Reset: arst_n clears all flags, events and time stamps and empties both
//     stages at once; no clearing pass.
// ----------------------------------------------------------------------------
module button_press_release_tracker #(
	parameter int CHANNELS = 8
) (
	input logic       clk,
	input logic       arst_n,
	bpr_req_if.sink   req,
	bpr_rsp_if.source rsp
);
	import bpr_pkg::*;

	// input stage
	bpr_req_t req_s1;
	logic     vld_s1;
	logic     go_s1;

	// result register
	bpr_rsp_t rsp_q;
	logic     rsp_vld_q;

	bpr_cmd_t cmd;
	bpr_rsp_t bank_rsp;

	// ticks never wait; a query needs room in the result register
	assign go_s1 = vld_s1 &&
		(req_s1.operation == OP_TICK || !rsp_vld_q || rsp.ready);

	assign req.ready = !vld_s1 || go_s1;

	assign cmd.tick  = go_s1 && (req_s1.operation == OP_TICK);
	assign cmd.query = go_s1 && (req_s1.operation == OP_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid)
			req_s1 <= req.payload;
	end

	bpr_bank #(
		.CHANNELS (CHANNELS)
	) u_bank (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.button_levels (req_s1.button_levels),
		.now_ms        (req_s1.now_ms),
		.channel       (req_s1.channel),
		.rsp           (bank_rsp)
	);

	// result register: loads on a query, empties when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (cmd.query) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query)
			rsp_q <= bank_rsp;
	end

	assign rsp.valid   = rsp_vld_q;
	assign rsp.payload = rsp_q;

endmodule

/* rtl/bpr_bank.sv */
// ----------------------------------------------------------------------------
// bpr_bank
// Per-channel flags and time stamps; tick update and query read/clear.
// ----------------------------------------------------------------------------
module bpr_bank #(
	parameter int CHANNELS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bpr_pkg::bpr_cmd_t            cmd,
	input  logic [bpr_pkg::LEVEL_W-1:0]  button_levels,
	input  logic [bpr_pkg::TIME_W-1:0]   now_ms,
	input  logic [bpr_pkg::CHAN_W-1:0]   channel,
	output bpr_pkg::bpr_rsp_t            rsp
);
	import bpr_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CHAN_W-1:0] CH_LIMIT = CHAN_W'(CHANNELS);

	logic              pressed_q       [CHANNELS];
	logic              released_q      [CHANNELS];
	logic              press_evt_q     [CHANNELS];
	logic              release_evt_q   [CHANNELS];
	logic [TIME_W-1:0] press_start_q   [CHANNELS];
	logic [TIME_W-1:0] press_last_q    [CHANNELS];
	logic [TIME_W-1:0] release_start_q [CHANNELS];
	logic [TIME_W-1:0] release_last_q  [CHANNELS];

	logic [CHANNELS-1:0] down;
	logic                in_range;
	logic [IDX_W-1:0]    idx;

	// channels without a level bit always read as released
	genvar g;
	generate
		for (g = 0; g < CHANNELS; g++) begin : g_lvl
			if (g < LEVEL_W) begin : g_has
				assign down[g] = button_levels[g];
			end else begin : g_none
				assign down[g] = 1'b0;
			end
		end
	endgenerate

	assign in_range = channel < CH_LIMIT;
	assign idx      = channel[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pressed_q[c]       <= 1'b0;
				released_q[c]      <= 1'b0;
				press_evt_q[c]     <= 1'b0;
				release_evt_q[c]   <= 1'b0;
				press_start_q[c]   <= '0;
				press_last_q[c]    <= '0;
				release_start_q[c] <= '0;
				release_last_q[c]  <= '0;
			end
		end else if (cmd.tick) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (down[c]) begin
					if (!pressed_q[c])
						press_start_q[c] <= now_ms;
					pressed_q[c]    <= 1'b1;
					press_evt_q[c]  <= 1'b1;
					press_last_q[c] <= now_ms;
					released_q[c]   <= 1'b0;
				end else begin
					if (pressed_q[c]) begin
						release_evt_q[c]   <= 1'b1;
						release_start_q[c] <= now_ms;
					end
					pressed_q[c]      <= 1'b0;
					released_q[c]     <= 1'b1;
					release_last_q[c] <= now_ms;
				end
			end
		end else if (cmd.query && in_range) begin
			press_evt_q[idx]   <= 1'b0;
			release_evt_q[idx] <= 1'b0;
		end
	end

	always_comb begin
		rsp = '0;
		if (in_range) begin
			rsp.is_pressed       = pressed_q[idx];
			rsp.is_released      = released_q[idx];
			rsp.press_seen       = press_evt_q[idx];
			rsp.release_seen     = release_evt_q[idx];
			rsp.press_duration   = press_last_q[idx] - press_start_q[idx];
			rsp.release_duration = release_last_q[idx] - release_start_q[idx];
		end else begin
			rsp.bad_channel = 1'b1;
		end
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button press/release tracker. A directed table
// covers reset state, time stamp extremes, wrapping durations, event clearing
// and bad channels. A random stream of tick and query beats follows, run in
// phases of sender idling and receiver stalls. Every query is predicted by a
// behavioural copy of the channel bank and checked field by field on rsp.
// ----------------------------------------------------------------------------
module tb_top;
	import bpr_pkg::*;

	localparam int NCHAN       = 8;
	localparam int PHASE_BEATS = 290;   // four phases, 1160 random beats
	localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either side
	localparam int TAIL_CYCLES = 10;    // idle cycles before the final report

	// one row of the directed table; report is only used when typed is set
	typedef struct {
		bpr_req_t beat;
		bit       typed;
		bpr_rsp_t report;
	} stim_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bpr_req_if req_ch ();
	bpr_rsp_if rsp_ch ();

	button_press_release_tracker #(
		.CHANNELS(NCHAN)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// ------------------------------------------------------------------------
	// Shadow of the channel bank. Bit and vector types start at zero, which
	// matches the state after reset; reset is applied only once.
	// ------------------------------------------------------------------------
	bit        held_down   [NCHAN];
	bit        held_up     [NCHAN];
	bit        press_evt   [NCHAN];
	bit        release_evt [NCHAN];
	bit [31:0] press_t0    [NCHAN];
	bit [31:0] press_t1    [NCHAN];
	bit [31:0] release_t0  [NCHAN];
	bit [31:0] release_t1  [NCHAN];

	bpr_rsp_t pending_reports[$];  // query results still owed by the block

	int          mismatches   = 0;
	int          idle_pct     = 0;  // chance per cycle that the sender holds off
	int          stall_pct    = 0;  // chance per cycle that rsp.ready is low
	int          quiet_cycles = 0;
	bit [7:0]    levels_now   = '0; // slowly changing levels, so presses last
	bit [31:0]   clock_ms     = '0;

	// 12 ns clock
	initial begin
		forever #6 clk = ~clk;
	end

	// Advance the shadow bank by one accepted beat. A query also yields the
	// report the block must return, then clears that channel's sticky events.
	function automatic void apply_tracker_beat(input bpr_req_t beat, output bit has_report,
			output bpr_rsp_t report);
		bit down;
		has_report = 1'b0;
		report     = '0;
		if (beat.operation == OP_TICK) begin
			for (int c = 0; c < NCHAN; c++) begin
				// a channel with no level bit reads as released
				down = (c < LEVEL_W) && beat.button_levels[c];
				if (down) begin
					// start stamp only on the rising edge, last stamp on every tick
					if (!held_down[c])
						press_t0[c] = beat.now_ms;
					held_down[c] = 1'b1;
					press_evt[c] = 1'b1;
					press_t1[c]  = beat.now_ms;
					held_up[c]   = 1'b0;
				end else begin
					// release event and start stamp only on the falling edge
					if (held_down[c]) begin
						release_evt[c] = 1'b1;
						release_t0[c]  = beat.now_ms;
					end
					held_down[c]  = 1'b0;
					held_up[c]    = 1'b1;
					release_t1[c] = beat.now_ms;
				end
			end
		end else begin
			has_report = 1'b1;
			if (beat.channel >= NCHAN) begin
				// bad channel: everything zero but the flag, state untouched
				report.bad_channel = 1'b1;
			end else begin
				report.is_pressed       = held_down[beat.channel];
				report.is_released      = held_up[beat.channel];
				report.press_seen       = press_evt[beat.channel];
				report.release_seen     = release_evt[beat.channel];
				report.press_duration   = press_t1[beat.channel] - press_t0[beat.channel];
				report.release_duration = release_t1[beat.channel] - release_t0[beat.channel];
				press_evt[beat.channel]   = 1'b0;
				release_evt[beat.channel] = 1'b0;
			end
		end
	endfunction

	function automatic bpr_req_t tick_beat(input bit [7:0] levels, input bit [31:0] now);
		bpr_req_t beat;
		beat               = '0;
		beat.operation     = OP_TICK;
		beat.button_levels = levels;
		beat.now_ms        = now;
		return beat;
	endfunction

	function automatic bpr_req_t query_beat(input bit [7:0] chan);
		bpr_req_t beat;
		beat           = '0;
		beat.operation = OP_QUERY;
		beat.channel   = chan;
		return beat;
	endfunction

	// Random beat. Unused fields carry noise. Levels mostly change one bit at
	// a time so presses and releases span many ticks; time mostly creeps
	// forward, with the odd big jump, wrap or step backwards.
	function automatic bpr_req_t random_beat();
		bpr_req_t beat;
		int       pick;
		beat.button_levels = 8'($urandom);
		beat.now_ms        = $urandom;
		beat.channel       = 8'($urandom);
		if ($urandom_range(0, 99) < 45) begin
			beat.operation = OP_QUERY;
			if ($urandom_range(0, 99) < 85)
				beat.channel = 8'($urandom_range(0, NCHAN - 1));
			else
				beat.channel = 8'($urandom_range(NCHAN, 255));
		end else begin
			beat.operation = OP_TICK;
			pick = $urandom_range(0, 99);
			if (pick < 60)
				levels_now ^= 8'(1 << $urandom_range(0, LEVEL_W - 1));
			else if (pick < 75)
				levels_now = 8'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 80)
				clock_ms += $urandom_range(0, 40);
			else if (pick < 92)
				clock_ms += $urandom;
			else if (pick < 96)
				clock_ms = $urandom;
			else if (pick < 98)
				clock_ms = '0;
			else
				clock_ms = '1;
			beat.button_levels = levels_now;
			beat.now_ms        = clock_ms;
		end
		return beat;
	endfunction

	// Offer one beat on req and hold it until accepted. The prediction is
	// made at the accepting edge; a typed expectation replaces it when given.
	task automatic send_beat(input bpr_req_t beat, input bit typed, input bpr_rsp_t typed_rsp);
		bit       has_report;
		bpr_rsp_t report;
		while ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= beat;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		apply_tracker_beat(beat, has_report, report);
		if (has_report)
			pending_reports.push_back(typed ? typed_rsp : report);
	endtask

	// sender holds off until every owed result has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// receiver: ready drawn afresh every cycle from the current stall rate
	always @(posedge clk) begin
		rsp_ch.ready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	// result checker: each rsp beat against the oldest owed report
	always @(posedge clk) begin
		bpr_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected rsp beat, expected none, got %p", $time,
					rsp_ch.payload);
			end else begin
				want = pending_reports.pop_front();
				check_field("is_pressed", 32'(want.is_pressed),
					32'(rsp_ch.payload.is_pressed));
				check_field("is_released", 32'(want.is_released),
					32'(rsp_ch.payload.is_released));
				check_field("press_seen", 32'(want.press_seen),
					32'(rsp_ch.payload.press_seen));
				check_field("release_seen", 32'(want.release_seen),
					32'(rsp_ch.payload.release_seen));
				check_field("press_duration", want.press_duration,
					rsp_ch.payload.press_duration);
				check_field("release_duration", want.release_duration,
					rsp_ch.payload.release_duration);
				check_field("bad_channel", 32'(want.bad_channel),
					32'(rsp_ch.payload.bad_channel));
			end
		end
	end

	// watchdog: too long with no beat on either channel ends the run
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t dir_rows[$];
		bpr_rsp_t  zero_rsp;
		bpr_rsp_t  bad_rsp;
		bpr_rsp_t  full_rsp;

		req_ch.valid   <= 1'b0;
		req_ch.payload <= '0;

		zero_rsp             = '0;
		bad_rsp              = '0;
		bad_rsp.bad_channel  = 1'b1;
		// all channels held from time 0 to the last time stamp, never released
		full_rsp                = '0;
		full_rsp.is_pressed     = 1'b1;
		full_rsp.press_seen     = 1'b1;
		full_rsp.press_duration = '1;

		// directed table
		// reset state: everything zero, not even the released flag
		dir_rows.push_back('{query_beat(8'd0), 1'b1, zero_rsp});
		dir_rows.push_back('{query_beat(8'd7), 1'b1, zero_rsp});
		// first channels out of range, and the top of the field
		dir_rows.push_back('{query_beat(8'd8), 1'b1, bad_rsp});
		dir_rows.push_back('{query_beat(8'd255), 1'b1, bad_rsp});
		// all pressed from 0 to the largest stamp
		dir_rows.push_back('{tick_beat(8'hff, 32'h0), 1'b0, zero_rsp});
		dir_rows.push_back('{tick_beat(8'hff, 32'hffff_ffff), 1'b0, zero_rsp});
		dir_rows.push_back('{query_beat(8'd0), 1'b1, full_rsp});
		// events now cleared on channel 0
		dir_rows.push_back('{query_beat(8'd0), 1'b0, zero_rsp});
		// falling edge, then a later stamp that runs backwards: duration wraps
		dir_rows.push_back('{tick_beat(8'h00, 32'd5), 1'b0, zero_rsp});
		dir_rows.push_back('{tick_beat(8'h00, 32'd3), 1'b0, zero_rsp});
		dir_rows.push_back('{query_beat(8'd3), 1'b0, zero_rsp});
		dir_rows.push_back('{query_beat(8'd7), 1'b0, zero_rsp});
		// alternating patterns flip every channel, the odd channels both ways
		dir_rows.push_back('{tick_beat(8'haa, 32'd100), 1'b0, zero_rsp});
		dir_rows.push_back('{tick_beat(8'h55, 32'd200), 1'b0, zero_rsp});
		dir_rows.push_back('{query_beat(8'd1), 1'b0, zero_rsp});
		dir_rows.push_back('{query_beat(8'd0), 1'b0, zero_rsp});
		dir_rows.push_back('{query_beat(8'd6), 1'b0, zero_rsp});
		dir_rows.push_back('{query_beat(8'd128), 1'b1, bad_rsp});
		// press held on channel 0, its last stamp across the sign boundary and back
		dir_rows.push_back('{tick_beat(8'h01, 32'h8000_0000), 1'b0, zero_rsp});
		dir_rows.push_back('{tick_beat(8'h01, 32'h7fff_ffff), 1'b0, zero_rsp});
		dir_rows.push_back('{query_beat(8'd0), 1'b0, zero_rsp});
		dir_rows.push_back('{query_beat(8'd2), 1'b0, zero_rsp});

		// reset held at the start, once
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].report);
		wait_drained();

		// random phases: flat out, sparse sender, stalling receiver, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 86;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 86;
				end
				default: begin
					idle_pct  = 37;
					stall_pct = 37;
				end
			endcase
			for (int n = 0; n < PHASE_BEATS; n++)
				send_beat(random_beat(), 1'b0, zero_rsp);
			// pause between phases until the block has caught up
			wait_drained();
		end

		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
